// ----- src/sm4_pkg.sv -----
// Shared types, constants and transform functions of the SM4 block cipher.
`timescale 1ns / 1ps

package sm4_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_rk_addr;
    typedef logic [1:0]  t_cfg_index;

    localparam int NumRounds = 32;

    localparam t_cfg_index CFG_KEY_HIGH     = 2'd0;
    localparam t_cfg_index CFG_KEY_LOW      = 2'd1;
    localparam t_cfg_index CFG_DECRYPT_MODE = 2'd2;

    localparam t_word FK0 = 32'hA3B1BAC6;
    localparam t_word FK1 = 32'h56AA3350;
    localparam t_word FK2 = 32'h677D9197;
    localparam t_word FK3 = 32'hB27022DC;

    localparam t_word CK [NumRounds] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
        32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
        32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
        32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
        32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
        32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
        32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
        32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic t_word sub_word(input t_word w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic t_word lin_enc(input t_word w);
        return w ^ {w[29:0], w[31:30]} ^ {w[21:0], w[31:22]}
                 ^ {w[13:0], w[31:14]} ^ {w[7:0], w[31:8]};
    endfunction

    function automatic t_word lin_key(input t_word w);
        return w ^ {w[18:0], w[31:19]} ^ {w[8:0], w[31:9]};
    endfunction

endpackage

// ----- src/sm4_block_cipher.sv -----
// Top level of the SM4 block cipher: control sequencer, key schedule and round datapath.
`timescale 1ns / 1ps

// SM4 ECB engine. One 128-bit word is taken while the engine is idle and runs
// one round per cycle through a shared S-box and linear-transform unit, with
// round keys read from a 32-entry memory that has a registered read port.
// After acceptance the engine prefetches the first round key, runs the
// 32 rounds, then loads the output register once it is free. After a
// write to either key register the next block first runs the 32-round key
// schedule, with one memory write per round.
// The result sits in an output register, so a new word is accepted while
// the previous result still waits. Configuration writes are taken at any
// time but are meant to be made only while the engine is idle; an index of
// three is ignored.
module sm4_block_cipher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  sm4_pkg::t_cfg_index   i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [63:0]           i_block_high,
    input  logic [63:0]           i_block_low,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_result_high,
    output logic [63:0]           o_result_low
);
    import sm4_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEY   = 3'd1;
    localparam logic [2:0] ST_PREF  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_keys_ready, n_keys_ready;
    logic        r_mode;
    logic [63:0] r_key_high, r_key_low;
    t_word       r_x [4];
    t_word       r_k [4];
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_res_high, r_res_low;

    logic        cfg_we;
    logic        in_fire;
    logic        out_free;
    logic        key_phase;
    t_word       t_in, t_out;
    t_word       rk_word;
    t_word       new_word;
    logic        ram_we;
    t_rk_addr    ram_raddr;
    t_rk_addr    next_round;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign key_phase   = (r_state == ST_KEY);
    assign o_out_valid = r_out_valid;
    assign o_result_high = r_res_high;
    assign o_result_low  = r_res_low;

    sm4_rk_ram u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (new_word),
        .i_raddr (ram_raddr),
        .o_rdata (rk_word)
    );

    sm4_tfunc u_tfunc (
        .i_word    (t_in),
        .i_key_sel (key_phase),
        .o_word    (t_out)
    );

    always_comb begin
        next_round = (r_state == ST_ROUND) ? r_cnt + 5'd1 : 5'd0;
        ram_raddr  = r_mode ? ~next_round : next_round;
        ram_we     = key_phase;
        if (key_phase) begin
            t_in     = r_k[1] ^ r_k[2] ^ r_k[3] ^ CK[r_cnt];
            new_word = r_k[0] ^ t_out;
        end else begin
            t_in     = r_x[1] ^ r_x[2] ^ r_x[3] ^ rk_word;
            new_word = r_x[0] ^ t_out;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_cnt   = 5'd0;
                    n_state = r_keys_ready ? ST_PREF : ST_KEY;
                end
            end
            ST_KEY: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_keys_ready = 1'b1;
                    n_state      = ST_PREF;
                end
            end
            ST_PREF: begin
                n_cnt   = 5'd0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cfg_we && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW)) begin
            n_keys_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= 5'd0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= 1'b0;
            r_key_high   <= 64'd0;
            r_key_low    <= 64'd0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_HIGH:     r_key_high <= i_cfg_data;
                    CFG_KEY_LOW:      r_key_low  <= i_cfg_data;
                    CFG_DECRYPT_MODE: r_mode     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x[0] <= i_block_high[63:32];
            r_x[1] <= i_block_high[31:0];
            r_x[2] <= i_block_low[63:32];
            r_x[3] <= i_block_low[31:0];
            r_k[0] <= r_key_high[63:32] ^ FK0;
            r_k[1] <= r_key_high[31:0] ^ FK1;
            r_k[2] <= r_key_low[63:32] ^ FK2;
            r_k[3] <= r_key_low[31:0] ^ FK3;
        end else if (r_state == ST_KEY) begin
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
            r_k[2] <= r_k[3];
            r_k[3] <= new_word;
        end else if (r_state == ST_ROUND) begin
            r_x[0] <= r_x[1];
            r_x[1] <= r_x[2];
            r_x[2] <= r_x[3];
            r_x[3] <= new_word;
        end
        if (r_state == ST_DRAIN && out_free) begin
            r_res_high <= {r_x[3], r_x[2]};
            r_res_low  <= {r_x[1], r_x[0]};
        end
    end

endmodule

// ----- src/sm4_rk_ram.sv -----
// Round-key memory: 32 words, one write port and one registered read port.
`timescale 1ns / 1ps

module sm4_rk_ram (
    input  logic             i_clk,
    input  logic             i_we,
    input  sm4_pkg::t_rk_addr i_waddr,
    input  sm4_pkg::t_word    i_wdata,
    input  sm4_pkg::t_rk_addr i_raddr,
    output sm4_pkg::t_word    o_rdata
);
    import sm4_pkg::*;

    t_word r_mem [NumRounds];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sm4_tfunc.sv -----
// Shared SM4 round transform: S-box layer followed by the data or key linear map.
`timescale 1ns / 1ps

module sm4_tfunc (
    input  sm4_pkg::t_word i_word,
    input  logic           i_key_sel,
    output sm4_pkg::t_word o_word
);
    import sm4_pkg::*;

    t_word sub;

    always_comb begin
        sub    = sub_word(i_word);
        o_word = i_key_sel ? lin_key(sub) : lin_enc(sub);
    end

endmodule

// ----- test/sm4_block_cipher_tb.sv -----
// Self-checking testbench for the SM4 block cipher with a built-in cipher predictor.
`timescale 1ns / 1ps

module sm4_block_cipher_tb;
    import sm4_pkg::*;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_block;

    localparam t_cfg_index CFG_UNUSED = 2'd3;
    localparam int unsigned TimeoutNs = 10_000_000;
    localparam t_block StdKey = {64'h0123456789abcdef, 64'hfedcba9876543210};
    localparam t_block StdCipher = {64'h681edf34d206965e, 64'h86b3e94f536e4246};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    logic [63:0] key_hi_m;
    logic [63:0] key_lo_m;
    logic        decrypt_m;
    t_word       rk_mem [NumRounds];
    logic        rk_loaded;

    t_block      cipher_out_q [$];
    t_block      want_blk;
    int          err_count;
    int          sink_wait;
    bit          no_idle;

    sm4_block_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_high (o_result_high),
        .o_result_low  (o_result_low)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_word rotl(input t_word w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic t_word tau(input t_word w);
        t_word r;
        int    b;
        for (b = 0; b < 4; b++) begin
            r[8*b +: 8] = SBOX[w[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic t_word ck_word(input int i);
        t_word r;
        int    j;
        for (j = 0; j < 4; j++) begin
            r[31-8*j -: 8] = 8'((4 * i + j) * 7);
        end
        return r;
    endfunction

    function automatic void expand_keys();
        t_word k [4];
        t_word nk;
        t_word t;
        int    r;
        k[0] = key_hi_m[63:32] ^ FK0;
        k[1] = key_hi_m[31:0] ^ FK1;
        k[2] = key_lo_m[63:32] ^ FK2;
        k[3] = key_lo_m[31:0] ^ FK3;
        for (r = 0; r < NumRounds; r++) begin
            t = tau(k[1] ^ k[2] ^ k[3] ^ ck_word(r));
            nk = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
            rk_mem[r] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        rk_loaded = 1'b1;
    endfunction

    function automatic t_block sm4_transform(input t_block b);
        t_word  x [4];
        t_word  t;
        t_word  nw;
        t_word  rk;
        int     r;
        t_block o;
        if (!rk_loaded) expand_keys();
        x[0] = b.high[63:32];
        x[1] = b.high[31:0];
        x[2] = b.low[63:32];
        x[3] = b.low[31:0];
        for (r = 0; r < NumRounds; r++) begin
            rk = decrypt_m ? rk_mem[NumRounds-1-r] : rk_mem[r];
            t = tau(x[1] ^ x[2] ^ x[3] ^ rk);
            nw = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nw;
        end
        o.high = {x[3], x[2]};
        o.low  = {x[1], x[0]};
        return o;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return 64'h1 << $urandom_range(0, 63);
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    task automatic push_block(input logic [63:0] hi, input logic [63:0] lo);
        int     gap;
        t_block b;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_block_high <= hi;
        i_block_low  <= lo;
        do @(posedge i_clk); while (!o_in_ready);
        b.high = hi;
        b.low  = lo;
        cipher_out_q.push_back(sm4_transform(b));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [63:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_HIGH: begin
                key_hi_m  = data;
                rk_loaded = 1'b0;
            end
            CFG_KEY_LOW: begin
                key_lo_m  = data;
                rk_loaded = 1'b0;
            end
            CFG_DECRYPT_MODE: begin
                decrypt_m = data[0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            i_out_ready <= 1'b0;
            sink_wait = sink_wait - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sink_wait = no_idle ? 0 : $urandom_range(0, 16);
            if (cipher_out_q.size() == 0) begin
                if (err_count < 10) begin
                    $display("Unexpected word: high %h low %h", o_result_high, o_result_low);
                end
                err_count++;
            end else begin
                want_blk = cipher_out_q.pop_front();
                if (o_result_high !== want_blk.high || o_result_low !== want_blk.low) begin
                    if (err_count < 10) begin
                        $display("Mismatch: high exp %h got %h, low exp %h got %h",
                                 want_blk.high, o_result_high, want_blk.low, o_result_low);
                    end
                    err_count++;
                end
            end
        end
    end

    task automatic test_reset_key();
        push_block('0, '0);
        push_block('1, '1);
        push_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    endtask

    task automatic test_known_answer();
        write_cfg(CFG_KEY_HIGH, StdKey.high);
        write_cfg(CFG_KEY_LOW, StdKey.low);
        push_block(StdKey.high, StdKey.low);
        if (cipher_out_q[$] !== StdCipher) begin
            $display("Predicted word %h differs from the published cipher text",
                     cipher_out_q[$]);
            err_count++;
        end
        write_cfg(CFG_DECRYPT_MODE, 64'h1);
        push_block(StdCipher.high, StdCipher.low);
        push_block(StdKey.high, StdKey.low);
    endtask

    task automatic test_key_extremes();
        write_cfg(CFG_DECRYPT_MODE, 64'h0);
        write_cfg(CFG_KEY_HIGH, '1);
        write_cfg(CFG_KEY_LOW, '1);
        push_block('0, '0);
        push_block('1, '1);
        push_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        write_cfg(CFG_KEY_LOW, '0);
        push_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        write_cfg(CFG_DECRYPT_MODE, 64'h1);
        push_block('1, '0);
        write_cfg(CFG_KEY_HIGH, '0);
        push_block('0, '1);
    endtask

    task automatic test_ignored_writes();
        write_cfg(CFG_UNUSED, '1);
        push_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        write_cfg(CFG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
        push_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        write_cfg(CFG_DECRYPT_MODE, 64'h8000_0000_0000_0001);
        push_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        write_cfg(CFG_UNUSED, '0);
        push_block('1, '1);
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < 1550) begin
            if ($urandom_range(0, 2) != 0) write_cfg(CFG_KEY_HIGH, rand_word());
            if ($urandom_range(0, 2) != 0) write_cfg(CFG_KEY_LOW, rand_word());
            if ($urandom_range(0, 1) != 0) write_cfg(CFG_DECRYPT_MODE, {$urandom, $urandom});
            if ($urandom_range(0, 7) == 0) write_cfg(CFG_UNUSED, {$urandom, $urandom});
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 80);
            for (k = 0; k < n; k++) begin
                push_block(rand_word(), rand_word());
            end
            sent += n;
            if ($urandom_range(0, 5) == 0) wait_idle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        #(TimeoutNs);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_KEY_HIGH;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_block_high = '0;
        i_block_low  = '0;
        i_out_ready  = 1'b0;
        key_hi_m     = '0;
        key_lo_m     = '0;
        decrypt_m    = 1'b0;
        rk_loaded    = 1'b0;
        err_count    = 0;
        sink_wait    = 0;
        no_idle      = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_key();
        test_known_answer();
        test_key_extremes();
        test_ignored_writes();
        test_random_traffic();
        wait_idle();
        repeat (80) @(negedge i_clk);
        if (err_count == 0 && cipher_out_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
